FILE: rtl/tpdbm_pkg.sv
// ----------------------------------------------------------------------------
// tpdbm_pkg
// Shared types and constants of the typed packet deframer with beacon match.
// ----------------------------------------------------------------------------
package tpdbm_pkg;

  localparam int BYTE_W     = 8;
  localparam int CHAN_W     = 32;
  localparam int DIST_W     = 64;
  localparam int KIND_W     = 4;
  localparam int INDEX_W    = 3;
  localparam int CNT_W      = 5;
  localparam int NUM_REGS   = 6;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam int POSITION_LEN = 28;
  localparam int RANGE_LEN    = 20;
  localparam int NID_BYTES    = 4;
  localparam int DIST_BYTES   = 8;

  // Queue depth between front and back; a power of two.
  localparam int Q_DEPTH = 2;

  localparam logic [BYTE_W-1:0] TYPE_NULL     = 8'd0;
  localparam logic [BYTE_W-1:0] TYPE_POSITION = 8'd1;
  localparam logic [BYTE_W-1:0] TYPE_NODE_ID  = 8'd3;
  localparam logic [BYTE_W-1:0] TYPE_OK       = 8'd4;
  localparam logic [BYTE_W-1:0] TYPE_BUSY     = 8'd5;
  localparam logic [BYTE_W-1:0] TYPE_ERROR    = 8'd6;
  localparam logic [BYTE_W-1:0] TYPE_RANGE    = 8'd7;
  localparam logic [BYTE_W-1:0] TYPE_ABORT    = 8'd9;

  typedef enum logic [KIND_W-1:0] {
    EV_POSITION   = 4'd0,
    EV_NODE_ID    = 4'd1,
    EV_ABORT      = 4'd2,
    EV_RANGE_HIT  = 4'd3,
    EV_RANGE_MISS = 4'd4,
    EV_OK         = 4'd5,
    EV_ERROR      = 4'd6,
    EV_BUSY       = 4'd7,
    EV_UNKNOWN    = 4'd8
  } event_t;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_POSITION = 4'b0010,
    ST_NODE_ID  = 4'b0100,
    ST_RANGE    = 4'b1000
  } front_state_t;

  typedef struct packed {
    event_t              kind;
    logic [BYTE_W-1:0]   node_id_value;
    logic [CHAN_W-1:0]   range_node_id;
    logic [DIST_W-1:0]   distance;
  } cmd_t;

endpackage

FILE: rtl/tpdbm_front.sv
// ----------------------------------------------------------------------------
// tpdbm_front
// Byte parser: tracks the packet type, collects range payload fields and
// posts one command per finished packet or immediate type byte.
// ----------------------------------------------------------------------------
module tpdbm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [tpdbm_pkg::BYTE_W-1:0]  rx_byte,
  output logic                          push,
  output tpdbm_pkg::cmd_t               cmd
);

  tpdbm_pkg::front_state_t state_r, state_nxt;
  logic [tpdbm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [tpdbm_pkg::CHAN_W-1:0] nid_r, nid_nxt;
  logic [tpdbm_pkg::DIST_W-1:0] dist_r, dist_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    nid_nxt   = nid_r;
    dist_nxt  = dist_r;
    push      = 1'b0;
    cmd       = '0;
    cmd.kind  = tpdbm_pkg::EV_UNKNOWN;
    if (accept) begin
      unique case (state_r)
        tpdbm_pkg::ST_IDLE: begin
          cnt_nxt = '0;
          unique case (rx_byte)
            tpdbm_pkg::TYPE_NULL: begin
            end
            tpdbm_pkg::TYPE_POSITION: begin
              state_nxt = tpdbm_pkg::ST_POSITION;
            end
            tpdbm_pkg::TYPE_NODE_ID: begin
              state_nxt = tpdbm_pkg::ST_NODE_ID;
            end
            tpdbm_pkg::TYPE_RANGE: begin
              state_nxt = tpdbm_pkg::ST_RANGE;
            end
            tpdbm_pkg::TYPE_OK: begin
              push     = 1'b1;
              cmd.kind = tpdbm_pkg::EV_OK;
            end
            tpdbm_pkg::TYPE_ERROR: begin
              push     = 1'b1;
              cmd.kind = tpdbm_pkg::EV_ERROR;
            end
            tpdbm_pkg::TYPE_BUSY: begin
              push     = 1'b1;
              cmd.kind = tpdbm_pkg::EV_BUSY;
            end
            tpdbm_pkg::TYPE_ABORT: begin
              push     = 1'b1;
              cmd.kind = tpdbm_pkg::EV_ABORT;
            end
            default: begin
              push     = 1'b1;
              cmd.kind = tpdbm_pkg::EV_UNKNOWN;
            end
          endcase
        end
        tpdbm_pkg::ST_POSITION: begin
          if (cnt_r == tpdbm_pkg::CNT_W'(tpdbm_pkg::POSITION_LEN - 1)) begin
            push      = 1'b1;
            cmd.kind  = tpdbm_pkg::EV_POSITION;
            state_nxt = tpdbm_pkg::ST_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        tpdbm_pkg::ST_NODE_ID: begin
          push              = 1'b1;
          cmd.kind          = tpdbm_pkg::EV_NODE_ID;
          cmd.node_id_value = rx_byte;
          state_nxt         = tpdbm_pkg::ST_IDLE;
        end
        tpdbm_pkg::ST_RANGE: begin
          for (int k = 0; k < tpdbm_pkg::NID_BYTES; k++) begin
            if (cnt_r == tpdbm_pkg::CNT_W'(k)) begin
              nid_nxt[8*k +: 8] = rx_byte;
            end
          end
          for (int k = 0; k < tpdbm_pkg::DIST_BYTES; k++) begin
            if (cnt_r == tpdbm_pkg::CNT_W'(tpdbm_pkg::NID_BYTES + k)) begin
              dist_nxt[8*k +: 8] = rx_byte;
            end
          end
          if (cnt_r == tpdbm_pkg::CNT_W'(tpdbm_pkg::RANGE_LEN - 1)) begin
            push              = 1'b1;
            cmd.kind          = tpdbm_pkg::EV_RANGE_HIT;
            cmd.range_node_id = nid_nxt;
            cmd.distance      = dist_nxt;
            state_nxt         = tpdbm_pkg::ST_IDLE;
            cnt_nxt           = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        default: begin
          state_nxt = tpdbm_pkg::ST_IDLE;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpdbm_pkg::ST_IDLE;
      cnt_r   <= '0;
      nid_r   <= '0;
      dist_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nid_r   <= nid_nxt;
      dist_r  <= dist_nxt;
    end
  end

  a_pos_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tpdbm_pkg::ST_POSITION |->
      cnt_r < tpdbm_pkg::CNT_W'(tpdbm_pkg::POSITION_LEN))
    else $error("position byte count out of range");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tpdbm_pkg::ST_IDLE |-> cnt_r == '0)
    else $error("byte count not cleared in idle");

endmodule

FILE: rtl/tpdbm_queue.sv
// ----------------------------------------------------------------------------
// tpdbm_queue
// Short command queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module tpdbm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tpdbm_pkg::cmd_t  push_cmd,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output tpdbm_pkg::cmd_t  head_cmd
);

  localparam int PTR_W = (tpdbm_pkg::Q_DEPTH > 1) ? $clog2(tpdbm_pkg::Q_DEPTH) : 1;

  tpdbm_pkg::cmd_t    entry_r [tpdbm_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     count_r, count_nxt;

  assign full       = (count_r == (PTR_W + 1)'(tpdbm_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("command queue underflow");

endmodule

FILE: rtl/tpdbm_back.sv
// ----------------------------------------------------------------------------
// tpdbm_back
// Result stage: resolves range commands against the beacon registers and
// holds the finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module tpdbm_back #(
  parameter int NUM_BEACONS = 6
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              head_valid,
  input  tpdbm_pkg::cmd_t                                   head_cmd,
  output logic                                              pop,
  input  logic [NUM_BEACONS-1:0][tpdbm_pkg::CHAN_W-1:0]     beacons,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [tpdbm_pkg::KIND_W-1:0]                      out_event_kind,
  output logic                                              out_send_ack,
  output logic [tpdbm_pkg::INDEX_W-1:0]                     out_beacon_index,
  output logic [tpdbm_pkg::DIST_W-1:0]                      out_distance_bits,
  output logic [tpdbm_pkg::BYTE_W-1:0]                      out_node_id_value
);

  logic                              valid_r, valid_nxt;
  tpdbm_pkg::event_t                 kind_r, kind_nxt;
  logic                              ack_r, ack_nxt;
  logic [tpdbm_pkg::INDEX_W-1:0]     index_r, index_nxt;
  logic [tpdbm_pkg::DIST_W-1:0]      dist_r, dist_nxt;
  logic [tpdbm_pkg::BYTE_W-1:0]      nid_r, nid_nxt;
  logic                              hit;
  logic [tpdbm_pkg::INDEX_W-1:0]     hit_index;

  assign pop = head_valid && (!valid_r || out_ready);

  always_comb begin
    hit       = 1'b0;
    hit_index = '0;
    for (int i = NUM_BEACONS - 1; i >= 0; i--) begin
      if (beacons[i] == head_cmd.range_node_id) begin
        hit       = 1'b1;
        hit_index = tpdbm_pkg::INDEX_W'(i);
      end
    end
  end

  always_comb begin
    kind_nxt  = head_cmd.kind;
    index_nxt = '0;
    if (head_cmd.kind == tpdbm_pkg::EV_RANGE_HIT) begin
      if (hit) begin
        index_nxt = hit_index;
      end else begin
        kind_nxt = tpdbm_pkg::EV_RANGE_MISS;
      end
    end
    case (head_cmd.kind)
      tpdbm_pkg::EV_POSITION, tpdbm_pkg::EV_NODE_ID, tpdbm_pkg::EV_ABORT,
      tpdbm_pkg::EV_RANGE_HIT, tpdbm_pkg::EV_RANGE_MISS: ack_nxt = 1'b1;
      default: ack_nxt = 1'b0;
    endcase
    dist_nxt  = head_cmd.distance;
    nid_nxt   = head_cmd.node_id_value;
    valid_nxt = pop ? 1'b1 : (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= kind_nxt;
      ack_r   <= ack_nxt;
      index_r <= index_nxt;
      dist_r  <= dist_nxt;
      nid_r   <= nid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_event_kind    = kind_r;
  assign out_send_ack      = ack_r;
  assign out_beacon_index  = index_r;
  assign out_distance_bits = dist_r;
  assign out_node_id_value = nid_r;

  a_ack_by_kind: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> out_send_ack == (kind_r == tpdbm_pkg::EV_POSITION ||
      kind_r == tpdbm_pkg::EV_NODE_ID || kind_r == tpdbm_pkg::EV_ABORT ||
      kind_r == tpdbm_pkg::EV_RANGE_HIT || kind_r == tpdbm_pkg::EV_RANGE_MISS))
    else $error("acknowledge does not follow event kind");

  a_index_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r != tpdbm_pkg::EV_RANGE_HIT |-> index_r == '0)
    else $error("beacon index set on a non-matching event");

  a_hit_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == tpdbm_pkg::EV_RANGE_HIT |->
      index_r < tpdbm_pkg::INDEX_W'(NUM_BEACONS - 1) + 1'b1 ||
      NUM_BEACONS == (1 << tpdbm_pkg::INDEX_W))
    else $error("matched beacon index beyond beacon count");

endmodule

FILE: rtl/typed_packet_deframer_beacon_match.sv
// ----------------------------------------------------------------------------
// typed_packet_deframer_beacon_match
// Typed packet deframer for a byte link with a beacon id match on range
// packets, configured over an APB-style register port.
// ----------------------------------------------------------------------------
// The block takes one byte beat per clock cycle while in_ready is high. A
// parser tracks the packet type and posts a command into a two-entry queue
// when a packet or an immediate type byte is complete; a result stage
// compares range node ids against all beacon registers combinationally and
// holds the result in an output register behind the queue entry. in_ready
// drops only while the queue is full because the consumer stalls.
// Beacon registers lie at byte addresses 0, 4, ... 20 and reset to minus one.
module typed_packet_deframer_beacon_match #(
  parameter int NUM_BEACONS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tpdbm_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tpdbm_pkg::KIND_W-1:0]         out_event_kind,
  output logic                                 out_send_ack,
  output logic [tpdbm_pkg::INDEX_W-1:0]        out_beacon_index,
  output logic [tpdbm_pkg::DIST_W-1:0]         out_distance_bits,
  output logic [tpdbm_pkg::BYTE_W-1:0]         out_node_id_value,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tpdbm_pkg::ADDR_W-1:0]         paddr,
  input  logic [tpdbm_pkg::DATA_W-1:0]         pwdata,
  output logic [tpdbm_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);

  localparam int IDX_W = tpdbm_pkg::ADDR_W - 2;

  logic [NUM_BEACONS-1:0][tpdbm_pkg::CHAN_W-1:0] beacon_r, beacon_nxt;
  logic [IDX_W-1:0]   reg_idx;
  logic               reg_wr;
  logic               accept;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               head_valid;
  tpdbm_pkg::cmd_t    push_cmd;
  tpdbm_pkg::cmd_t    head_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[tpdbm_pkg::ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    beacon_nxt = beacon_r;
    prdata     = '0;
    for (int i = 0; i < NUM_BEACONS; i++) begin
      if (i < tpdbm_pkg::NUM_REGS && reg_idx == IDX_W'(i)) begin
        prdata = beacon_r[i];
        if (reg_wr) begin
          beacon_nxt[i] = pwdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beacon_r <= '1;
    end else begin
      beacon_r <= beacon_nxt;
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  tpdbm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .push    (push),
    .cmd     (push_cmd)
  );

  tpdbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tpdbm_back #(
    .NUM_BEACONS (NUM_BEACONS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_cmd          (head_cmd),
    .pop               (pop),
    .beacons           (beacon_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_send_ack      (out_send_ack),
    .out_beacon_index  (out_beacon_index),
    .out_distance_bits (out_distance_bits),
    .out_node_id_value (out_node_id_value)
  );

endmodule

FILE: dv/tpdbm_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpdbm_event_checker
// Watches the byte and event channels of the deframer, tracks the beacon
// registers written over the register port, predicts the event that each
// byte beat closes and compares every event beat against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tpdbm_event_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [tpdbm_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [tpdbm_pkg::KIND_W-1:0]    out_event_kind,
  input  logic                            out_send_ack,
  input  logic [tpdbm_pkg::INDEX_W-1:0]   out_beacon_index,
  input  logic [tpdbm_pkg::DIST_W-1:0]    out_distance_bits,
  input  logic [tpdbm_pkg::BYTE_W-1:0]    out_node_id_value,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [tpdbm_pkg::ADDR_W-1:0]    paddr,
  input  logic [tpdbm_pkg::DATA_W-1:0]    pwdata,
  output int                              mismatches,
  output int                              events_waiting,
  output int                              events_checked
);

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [tpdbm_pkg::KIND_W-1:0]  kind;
    logic                          ack;
    logic [tpdbm_pkg::INDEX_W-1:0] index;
    logic [tpdbm_pkg::DIST_W-1:0]  distance;
    logic [tpdbm_pkg::BYTE_W-1:0]  node_id;
  } deframe_event_t;

  logic [tpdbm_pkg::CHAN_W-1:0] beacon_chan [tpdbm_pkg::NUM_REGS];
  tpdbm_pkg::front_state_t      frame_state;
  logic [tpdbm_pkg::CNT_W-1:0]  bytes_to_go;
  logic [tpdbm_pkg::CHAN_W-1:0] rng_node_id;
  logic [tpdbm_pkg::DIST_W-1:0] rng_distance;
  logic [tpdbm_pkg::BYTE_W-1:0] own_node_id;
  deframe_event_t               expected_events [$];
  int                           mism_n;
  int                           checked_n;

  function automatic bit deframe_byte(input logic [tpdbm_pkg::BYTE_W-1:0] b,
                                      output deframe_event_t ev);
    int  off;
    bit  fired;
    fired = 1'b0;
    ev    = '{kind: tpdbm_pkg::EV_POSITION, ack: 1'b0, index: '0, distance: '0,
              node_id: '0};
    case (frame_state)
      tpdbm_pkg::ST_IDLE: begin
        case (b)
          tpdbm_pkg::TYPE_NULL: fired = 1'b0;
          tpdbm_pkg::TYPE_POSITION: begin
            frame_state = tpdbm_pkg::ST_POSITION;
            bytes_to_go = tpdbm_pkg::CNT_W'(tpdbm_pkg::POSITION_LEN);
          end
          tpdbm_pkg::TYPE_NODE_ID: begin
            frame_state = tpdbm_pkg::ST_NODE_ID;
            bytes_to_go = '0;
          end
          tpdbm_pkg::TYPE_RANGE: begin
            frame_state = tpdbm_pkg::ST_RANGE;
            bytes_to_go = tpdbm_pkg::CNT_W'(tpdbm_pkg::RANGE_LEN);
          end
          tpdbm_pkg::TYPE_OK: begin
            ev.kind = tpdbm_pkg::EV_OK;
            fired   = 1'b1;
          end
          tpdbm_pkg::TYPE_ERROR: begin
            ev.kind = tpdbm_pkg::EV_ERROR;
            fired   = 1'b1;
          end
          tpdbm_pkg::TYPE_BUSY: begin
            ev.kind = tpdbm_pkg::EV_BUSY;
            fired   = 1'b1;
          end
          tpdbm_pkg::TYPE_ABORT: begin
            ev.kind = tpdbm_pkg::EV_ABORT;
            ev.ack  = 1'b1;
            fired   = 1'b1;
          end
          default: begin
            ev.kind = tpdbm_pkg::EV_UNKNOWN;
            fired   = 1'b1;
          end
        endcase
      end
      tpdbm_pkg::ST_POSITION: begin
        if (bytes_to_go != 0) bytes_to_go = bytes_to_go - 1'b1;
        if (bytes_to_go == 0) begin
          frame_state = tpdbm_pkg::ST_IDLE;
          ev.kind     = tpdbm_pkg::EV_POSITION;
          ev.ack      = 1'b1;
          fired       = 1'b1;
        end
      end
      tpdbm_pkg::ST_NODE_ID: begin
        own_node_id = b;
        frame_state = tpdbm_pkg::ST_IDLE;
        bytes_to_go = '0;
        ev.kind     = tpdbm_pkg::EV_NODE_ID;
        ev.ack      = 1'b1;
        ev.node_id  = own_node_id;
        fired       = 1'b1;
      end
      tpdbm_pkg::ST_RANGE: begin
        if (bytes_to_go == 0 || bytes_to_go > tpdbm_pkg::RANGE_LEN) begin
          bytes_to_go = tpdbm_pkg::CNT_W'(tpdbm_pkg::RANGE_LEN);
        end
        off = tpdbm_pkg::RANGE_LEN - int'(bytes_to_go);
        if (off < tpdbm_pkg::NID_BYTES) begin
          rng_node_id[8*off +: 8] = b;
        end else if (off < tpdbm_pkg::NID_BYTES + tpdbm_pkg::DIST_BYTES) begin
          rng_distance[8*(off-tpdbm_pkg::NID_BYTES) +: 8] = b;
        end
        bytes_to_go = bytes_to_go - 1'b1;
        if (bytes_to_go == 0) begin
          frame_state = tpdbm_pkg::ST_IDLE;
          ev.kind     = tpdbm_pkg::EV_RANGE_MISS;
          ev.ack      = 1'b1;
          ev.distance = rng_distance;
          for (int i = tpdbm_pkg::NUM_REGS - 1; i >= 0; i--) begin
            if (beacon_chan[i] == rng_node_id) begin
              ev.kind  = tpdbm_pkg::EV_RANGE_HIT;
              ev.index = tpdbm_pkg::INDEX_W'(i);
            end
          end
          fired = 1'b1;
        end
      end
      default: begin
        frame_state = tpdbm_pkg::ST_IDLE;
        bytes_to_go = '0;
      end
    endcase
    return fired;
  endfunction

  task automatic report_event(input string what, input deframe_event_t want,
                              input deframe_event_t got);
    mism_n++;
    if (mism_n <= MAX_REPORTS) begin
      $display("ERROR %0t: %s", $realtime, what);
      $display("  expected kind=%0d ack=%0d index=%0d dist=%h node_id=%h",
               want.kind, want.ack, want.index, want.distance, want.node_id);
      $display("  actual   kind=%0d ack=%0d index=%0d dist=%h node_id=%h",
               got.kind, got.ack, got.index, got.distance, got.node_id);
    end
  endtask

  task automatic check_event(input deframe_event_t got);
    deframe_event_t want;
    checked_n++;
    if (expected_events.size() == 0) begin
      want = '{kind: 'x, ack: 'x, index: 'x, distance: 'x, node_id: 'x};
      report_event("event beat with no event predicted", want, got);
    end else begin
      want = expected_events.pop_front();
      if (got.kind !== want.kind || got.ack !== want.ack || got.index !== want.index ||
          got.distance !== want.distance || got.node_id !== want.node_id) begin
        report_event("event beat differs from prediction", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    deframe_event_t ev;
    deframe_event_t got;
    if (!rst_n) begin
      for (int i = 0; i < tpdbm_pkg::NUM_REGS; i++) beacon_chan[i] = '1;
      frame_state  = tpdbm_pkg::ST_IDLE;
      bytes_to_go  = '0;
      rng_node_id  = '0;
      rng_distance = '0;
      own_node_id  = '0;
      expected_events.delete();
      mism_n    = 0;
      checked_n = 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[tpdbm_pkg::ADDR_W-1:2] < tpdbm_pkg::NUM_REGS) begin
        beacon_chan[paddr[tpdbm_pkg::ADDR_W-1:2]] = pwdata[tpdbm_pkg::CHAN_W-1:0];
      end
      if (out_valid && out_ready) begin
        got = '{kind: out_event_kind, ack: out_send_ack, index: out_beacon_index,
                distance: out_distance_bits, node_id: out_node_id_value};
        check_event(got);
      end
      if (in_valid && in_ready) begin
        if (deframe_byte(in_rx_byte, ev)) expected_events = {expected_events, ev};
      end
    end
    mismatches     <= mism_n;
    events_waiting <= expected_events.size();
    events_checked <= checked_n;
  end

endmodule

FILE: dv/tb_typed_packet_deframer_beacon_match.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_typed_packet_deframer_beacon_match
// Drives byte beats, register writes and output back-pressure into the
// deframer and gives the verdict from the checker's mismatch count. A short
// directed part covers all type bytes but position and range, followed by
// random packet streams under four handshake modes and four beacon settings.
// ----------------------------------------------------------------------------
module tb_typed_packet_deframer_beacon_match;

  localparam int PHASES         = 4;
  localparam int PHASE_ITEMS    = 410;
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TX_IDLE_PCT  [PHASES] = '{0, 79, 0, 14};
  localparam int RX_STALL_PCT [PHASES] = '{0, 0, 79, 14};
  localparam logic [tpdbm_pkg::ADDR_W-1:0] UNMAPPED_ADDR =
    tpdbm_pkg::ADDR_W'(4 * tpdbm_pkg::NUM_REGS);
  localparam logic [tpdbm_pkg::CHAN_W-1:0] GHOST_ID = 32'h1234_5678;
  localparam logic [tpdbm_pkg::CHAN_W-1:0] SETTING_MIXED [tpdbm_pkg::NUM_REGS] =
    '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd12345, 32'd1};
  localparam logic [tpdbm_pkg::CHAN_W-1:0] SETTING_EDGES [tpdbm_pkg::NUM_REGS] =
    '{32'h7FFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd1, 32'd2};
  localparam logic [tpdbm_pkg::BYTE_W-1:0] UNDEF_TYPES [4] =
    '{8'd2, 8'd8, 8'd10, 8'hFF};

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [tpdbm_pkg::BYTE_W-1:0] in_rx_byte;
  logic out_valid;
  logic out_ready;
  logic [tpdbm_pkg::KIND_W-1:0] out_event_kind;
  logic out_send_ack;
  logic [tpdbm_pkg::INDEX_W-1:0] out_beacon_index;
  logic [tpdbm_pkg::DIST_W-1:0] out_distance_bits;
  logic [tpdbm_pkg::BYTE_W-1:0] out_node_id_value;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tpdbm_pkg::ADDR_W-1:0] paddr;
  logic [tpdbm_pkg::DATA_W-1:0] pwdata;
  logic [tpdbm_pkg::DATA_W-1:0] prdata;
  logic pready;

  int chk_mismatches;
  int chk_waiting;
  int chk_checked;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_armed   = 1'b0;
  int beats_sent   = 0;
  int nulls_sent   = 0;
  int quiet_cycles = 0;
  logic [tpdbm_pkg::CHAN_W-1:0] beacon_set [tpdbm_pkg::NUM_REGS];

  always #5 clk = ~clk;

  typed_packet_deframer_beacon_match DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_send_ack      (out_send_ack),
    .out_beacon_index  (out_beacon_index),
    .out_distance_bits (out_distance_bits),
    .out_node_id_value (out_node_id_value),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  tpdbm_event_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_send_ack      (out_send_ack),
    .out_beacon_index  (out_beacon_index),
    .out_distance_bits (out_distance_bits),
    .out_node_id_value (out_node_id_value),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .mismatches        (chk_mismatches),
    .events_waiting    (chk_waiting),
    .events_checked    (chk_checked)
  );

  // The output side stalls at random, and once holds off for a long stretch
  // so that the block fills up and pushes back on the byte beats.
  initial begin
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_armed && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d events still due",
                 WATCHDOG_LIMIT, chk_waiting);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [tpdbm_pkg::BYTE_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic reg_write(input logic [tpdbm_pkg::ADDR_W-1:0] a,
                           input logic [tpdbm_pkg::DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_beacons(input int setting);
    for (int i = 0; i < tpdbm_pkg::NUM_REGS; i++) begin
      case (setting)
        0: beacon_set[i] = SETTING_MIXED[i];
        1: beacon_set[i] = '1;
        2: beacon_set[i] = SETTING_EDGES[i];
        default: begin
          if ($urandom_range(3) == 0) beacon_set[i] = '1;
          else beacon_set[i] = tpdbm_pkg::CHAN_W'($urandom_range(32'h7FFF_FFFF, 0));
        end
      endcase
      reg_write(tpdbm_pkg::ADDR_W'(4 * i), beacon_set[i]);
    end
    // A write past the last beacon register must leave all beacons alone.
    if (setting == 0) reg_write(UNMAPPED_ADDR, GHOST_ID);
  endtask

  function automatic logic [tpdbm_pkg::CHAN_W-1:0] pick_node_id();
    int r;
    r = $urandom_range(99);
    if (r < 50) return beacon_set[$urandom_range(tpdbm_pkg::NUM_REGS - 1)];
    if (r < 60) return '1;
    if (r < 65) return GHOST_ID;
    if (r < 70) return 32'h8000_0000;
    return $urandom();
  endfunction

  task automatic send_range(input logic [tpdbm_pkg::CHAN_W-1:0] nid, input int payload_len);
    logic [tpdbm_pkg::DIST_W-1:0] range_dist;
    int r;
    r = $urandom_range(9);
    if (r == 0) range_dist = '0;
    else if (r == 1) range_dist = '1;
    else range_dist = {$urandom(), $urandom()};
    send_byte(tpdbm_pkg::TYPE_RANGE);
    for (int k = 0; k < payload_len; k++) begin
      if (k < tpdbm_pkg::NID_BYTES) begin
        send_byte(nid[8*k +: 8]);
      end else if (k < tpdbm_pkg::NID_BYTES + tpdbm_pkg::DIST_BYTES) begin
        send_byte(range_dist[8*(k-tpdbm_pkg::NID_BYTES) +: 8]);
      end else begin
        send_byte(tpdbm_pkg::BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic send_random_packet();
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      send_byte(tpdbm_pkg::TYPE_NULL);
      nulls_sent++;
    end else if (pick < 32) begin
      send_range(pick_node_id(), tpdbm_pkg::RANGE_LEN);
    end else if (pick < 42) begin
      send_byte(tpdbm_pkg::TYPE_POSITION);
      repeat (tpdbm_pkg::POSITION_LEN) send_byte(tpdbm_pkg::BYTE_W'($urandom_range(255)));
    end else if (pick < 57) begin
      send_byte(tpdbm_pkg::TYPE_NODE_ID);
      send_byte(tpdbm_pkg::BYTE_W'($urandom_range(255)));
    end else if (pick < 87) begin
      case ($urandom_range(3))
        0: send_byte(tpdbm_pkg::TYPE_OK);
        1: send_byte(tpdbm_pkg::TYPE_ERROR);
        2: send_byte(tpdbm_pkg::TYPE_BUSY);
        default: send_byte(tpdbm_pkg::TYPE_ABORT);
      endcase
    end else if (pick < 94) begin
      send_byte(tpdbm_pkg::BYTE_W'($urandom_range(255)));
    end else begin
      send_range(pick_node_id(), $urandom_range(tpdbm_pkg::RANGE_LEN - 1, 1));
    end
  endtask

  initial begin
    int phase_start;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_beacons(0);
    send_byte(tpdbm_pkg::TYPE_NULL);
    send_byte(tpdbm_pkg::TYPE_OK);
    send_byte(tpdbm_pkg::TYPE_ERROR);
    send_byte(tpdbm_pkg::TYPE_BUSY);
    send_byte(tpdbm_pkg::TYPE_ABORT);
    for (int i = 0; i < 4; i++) send_byte(UNDEF_TYPES[i]);
    send_byte(tpdbm_pkg::TYPE_NODE_ID);
    send_byte(8'h00);
    send_byte(tpdbm_pkg::TYPE_NODE_ID);
    send_byte(8'hFF);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        load_beacons(ph);
      end
      tx_idle_pct  = TX_IDLE_PCT[ph];
      rx_stall_pct = RX_STALL_PCT[ph];
      if (ph == 0) hold_armed = 1'b1;
      phase_start = beats_sent - nulls_sent;
      while (beats_sent - nulls_sent - phase_start < PHASE_ITEMS) send_random_packet();
    end
    drain();

    $display("Summary: %0d byte beats (%0d null type bytes), %0d event beats checked,",
             beats_sent, nulls_sent, chk_checked);
    $display("  four handshake modes, four beacon settings, one long output hold-off.");
    if (chk_mismatches == 0 && chk_waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tpdbm_pkg.sv
rtl/tpdbm_front.sv
rtl/tpdbm_queue.sv
rtl/tpdbm_back.sv
rtl/typed_packet_deframer_beacon_match.sv
dv/tpdbm_event_checker.sv
dv/tb_typed_packet_deframer_beacon_match.sv
